@@ hdl/rppc_pkg.sv @@
// Shared types and constants for the reflow profile PID controller.
// No dependencies; rppc_pid_mac and the top level refer to this package by scoped names.
package rppc_pkg;

   // Command codes of a request transaction
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_START = 2'd2;

   // Oven phases
   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_REFLOW = 2'd1;
   localparam logic [1:0] PH_COOL   = 2'd2;

   // Configuration register indexes
   localparam logic [2:0] CSR_NUM_STEPS      = 3'd0;
   localparam logic [2:0] CSR_P_GAIN         = 3'd1;
   localparam logic [2:0] CSR_I_GAIN         = 3'd2;
   localparam logic [2:0] CSR_D_GAIN         = 3'd3;
   localparam logic [2:0] CSR_INTEGRAL_LIMIT = 3'd4;
   localparam logic [2:0] CSR_DONE_TEMP      = 3'd5;

   // Target in 1/512 C units
   localparam int         TARGET_W     = 18;
   localparam logic [17:0] TARGET_START = 18'd25600;
   localparam logic [17:0] TARGET_COOL  = 18'd12800;
   localparam logic [17:0] TARGET_MAX   = 18'h3FFFF;
   localparam logic [15:0] SECONDS_MAX  = 16'hFFFF;

   // PID datapath widths
   localparam int ERR_W  = 14;
   localparam int GAIN_W = 9;
   localparam int PROD_W = ERR_W + GAIN_W;
   localparam int ACC_W  = PROD_W + 1;

   typedef struct packed {
      logic [7:0] p_gain;
      logic [7:0] i_gain;
      logic [7:0] d_gain;
   } gains_type;

   typedef struct packed {
      logic [8:0]  target_temp;
      logic [1:0]  phase;
      logic [15:0] elapsed_seconds;
      logic [3:0]  current_step;
   } status_type;

   typedef struct packed {
      logic                    run_pid;
      logic signed [ERR_W-1:0] err;
      logic signed [ERR_W-1:0] err_sum;
      logic signed [ERR_W-1:0] err_diff;
      status_type              status;
   } pid_job_type;

   typedef struct packed {
      logic [7:0] drive;
      status_type status;
   } result_type;

endpackage

@@ hdl/rppc_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module rppc_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 8,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/rppc_pid_mac.sv @@
// PID sum unit: one shared multiplier runs the P, I and D products in turn.
// Depends on rppc_pkg for the job, gain and result types.
module rppc_pid_mac (
   input  logic                     clock,
   input  logic                     reset,
   input  rppc_pkg::gains_type      gains,
   input  logic                     job_valid,
   input  rppc_pkg::pid_job_type    job,
   output logic                     job_ready,
   output logic                     res_valid,
   output rppc_pkg::result_type     res,
   input  logic                     res_take
);

   localparam logic [1:0] MAC_P   = 2'd0;
   localparam logic [1:0] MAC_I   = 2'd1;
   localparam logic [1:0] MAC_D   = 2'd2;
   localparam logic [1:0] MAC_SUM = 2'd3;

   logic [1:0]                               state_ff, state_in;
   logic                                     busy_ff, busy_in;
   rppc_pkg::pid_job_type                    job_ff;
   logic signed [rppc_pkg::PROD_W-1:0]       prod_ff, prod_in;
   logic signed [rppc_pkg::ACC_W-1:0]        acc_ff, acc_in;
   logic signed [rppc_pkg::GAIN_W-1:0]       gain_op;
   logic signed [rppc_pkg::ERR_W-1:0]        data_op;
   logic signed [rppc_pkg::PROD_W-1:0]       product;
   logic signed [rppc_pkg::ACC_W-1:0]        total;
   logic                                     finish;
   logic                                     load;
   logic [7:0]                               drive;

   // Operand select for the shared multiplier
   always_comb begin
      unique case (state_ff)
         MAC_P: begin
            gain_op = $signed({1'b0, gains.p_gain});
            data_op = job_ff.err;
         end
         MAC_I: begin
            gain_op = $signed({1'b0, gains.i_gain});
            data_op = job_ff.err_sum;
         end
         default: begin
            gain_op = $signed({1'b0, gains.d_gain});
            data_op = job_ff.err_diff;
         end
      endcase
   end

   assign product = gain_op * data_op;
   assign total   = acc_ff + rppc_pkg::ACC_W'(prod_ff);

   assign res_valid = busy_ff && (state_ff == MAC_SUM);
   assign finish    = res_valid && res_take;
   assign job_ready = !busy_ff || finish;
   assign load      = job_valid && job_ready;

   always_comb begin
      state_in = state_ff;
      busy_in  = busy_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      if (busy_ff && (state_ff != MAC_SUM)) begin
         prod_in  = product;
         acc_in   = (state_ff == MAC_P) ? '0 : total;
         state_in = state_ff + 2'd1;
      end
      if (load) begin
         busy_in  = 1'b1;
         state_in = MAC_P;
      end else if (finish) begin
         busy_in = 1'b0;
      end
   end

   // Saturate the sum to the heater drive range; drive is zero when no PID run is requested
   always_comb begin
      if (!job_ff.run_pid) begin
         drive = 8'd0;
      end else if (total >= rppc_pkg::ACC_W'(255)) begin
         drive = 8'hFF;
      end else if (total <= rppc_pkg::ACC_W'(0)) begin
         drive = 8'd0;
      end else begin
         drive = total[7:0];
      end
   end

   assign res.drive  = drive;
   assign res.status = job_ff.status;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         state_ff <= MAC_P;
      end else begin
         busy_ff  <= busy_in;
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (load) begin
         job_ff <= job;
      end
   end

endmodule

@@ hdl/reflow_profile_pid_controller.sv @@
// Reflow oven profile controller: profile RAMs, step sequencer and PID loop.
// Depends on rppc_pkg, rppc_ram (profile store) and rppc_pid_mac (PID sum).
//
// A request passes the profile RAM read and the update, then the P, I, D and
// sum states of rppc_pid_mac and the response register. The sum unit sets the
// pace: three passes of the PID products through the single shared multiplier
// plus a sum state; the front end holds each request for a RAM read and an update.
// Reset (synchronous, active high): phase idle, target 50 C, time, step and
// PID state cleared, registers to their defaults; profile RAMs keep contents.
module reflow_profile_pid_controller #(
   parameter int MAX_STEPS        = 8,
   parameter int TICKS_PER_SECOND = 10
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic signed [11:0] req_temperature,
   input  logic [2:0]         req_step_index,
   input  logic [15:0]        req_step_end_time,
   input  logic signed [15:0] req_step_rate,
   input  logic [7:0]         req_step_ceiling,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_drive,
   output logic [8:0]         rsp_target_temp,
   output logic [1:0]         rsp_phase,
   output logic [15:0]        rsp_elapsed_seconds,
   output logic [3:0]         rsp_current_step,
   // configuration write channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [7:0]         csr_wdata
);

   localparam int         AW    = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
   localparam int         TDW   = $clog2(TICKS_PER_SECOND + 1);
   localparam logic [4:0] MAX5  = 5'(MAX_STEPS);
   localparam logic [TDW-1:0] TPS_C = TDW'(TICKS_PER_SECOND);
   localparam int         CUR_W = 40;
   localparam int         NXT_W = 24;
   localparam int         ERR_W = rppc_pkg::ERR_W;

   // front-end sequencer codes
   localparam logic [1:0] FE_EMPTY  = 2'd0;
   localparam logic [1:0] FE_READ   = 2'd1;
   localparam logic [1:0] FE_UPDATE = 2'd2;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [3:0]          num_steps_ff, num_steps_in;
   rppc_pkg::gains_type gains_ff, gains_in;
   logic [7:0]          int_limit_ff, int_limit_in;
   logic [7:0]          done_temp_ff, done_temp_in;
   logic                csr_fire;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   always_comb begin
      num_steps_in = num_steps_ff;
      gains_in     = gains_ff;
      int_limit_in = int_limit_ff;
      done_temp_in = done_temp_ff;
      if (csr_fire) begin
         unique case (csr_index)
            rppc_pkg::CSR_NUM_STEPS:      num_steps_in    = csr_wdata[3:0];
            rppc_pkg::CSR_P_GAIN:         gains_in.p_gain = csr_wdata;
            rppc_pkg::CSR_I_GAIN:         gains_in.i_gain = csr_wdata;
            rppc_pkg::CSR_D_GAIN:         gains_in.d_gain = csr_wdata;
            rppc_pkg::CSR_INTEGRAL_LIMIT: int_limit_in    = csr_wdata;
            rppc_pkg::CSR_DONE_TEMP:      done_temp_in    = csr_wdata;
            default: ;  // drop writes past the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_steps_ff <= 4'd4;
         gains_ff     <= '{p_gain: 8'd80, i_gain: 8'd150, d_gain: 8'd0};
         int_limit_ff <= 8'd200;
         done_temp_ff <= 8'd30;
      end else begin
         num_steps_ff <= num_steps_in;
         gains_ff     <= gains_in;
         int_limit_ff <= int_limit_in;
         done_temp_ff <= done_temp_in;
      end
   end

   // ------------------------------------------------------------------
   // Front end: hold one request for a RAM read cycle and an update cycle
   // ------------------------------------------------------------------
   logic [1:0]         fe_state_ff, fe_state_in;
   logic               req_accept;
   logic               fe_done;
   logic               mac_job_ready;
   logic [1:0]         cmd_ff;
   logic signed [11:0] temp_ff;
   logic [2:0]         idx_ff;
   logic [15:0]        end_ff;
   logic signed [15:0] rate_ff;
   logic [7:0]         ceil_ff;

   assign fe_done    = (fe_state_ff == FE_UPDATE) && mac_job_ready;
   assign req_stall  = !((fe_state_ff == FE_EMPTY) || fe_done);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      unique case (fe_state_ff)
         FE_EMPTY:  fe_state_in = req_accept ? FE_READ : FE_EMPTY;
         FE_READ:   fe_state_in = FE_UPDATE;
         FE_UPDATE: begin
            if (fe_done) begin
               fe_state_in = req_accept ? FE_READ : FE_EMPTY;
            end else begin
               fe_state_in = FE_UPDATE;
            end
         end
         default:   fe_state_in = FE_EMPTY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fe_state_ff <= FE_EMPTY;
      end else begin
         fe_state_ff <= fe_state_in;
      end
   end

   // capture the request payload; it holds until the update cycle retires
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff  <= req_command;
         temp_ff <= req_temperature;
         idx_ff  <= req_step_index;
         end_ff  <= req_step_end_time;
         rate_ff <= req_step_rate;
         ceil_ff <= req_step_ceiling;
      end
   end

   // ------------------------------------------------------------------
   // Controller state
   // ------------------------------------------------------------------
   logic [1:0]              phase_ff, phase_in;
   logic [3:0]              step_now_ff, step_now_in;
   logic [TDW-1:0]          tick_div_ff, tick_div_in;
   logic [15:0]             seconds_ff, seconds_in;
   logic [17:0]             target_ff, target_in;
   logic signed [8:0]       error_sum_ff, error_sum_in;
   logic signed [ERR_W-1:0] prev_err_ff, prev_err_in;

   // ------------------------------------------------------------------
   // Profile store: one copy read at the current step, one at the next
   // ------------------------------------------------------------------
   logic [4:0]        idx_wide;
   logic [4:0]        step_cur5;
   logic [4:0]        step_plus;
   logic              ram_wr_en;
   logic              ram_rd_en;
   logic [CUR_W-1:0]  cur_rd;
   logic [NXT_W-1:0]  nxt_rd;

   function automatic logic [AW-1:0] clip_addr(input logic [4:0] i);
      logic [4:0] c;
      c = (i < MAX5) ? i : (MAX5 - 5'd1);
      return c[AW-1:0];
   endfunction

   assign idx_wide  = {2'b00, idx_ff};
   assign step_cur5 = {1'b0, step_now_ff};
   assign step_plus = step_cur5 + 5'd1;
   assign ram_wr_en = fe_done && (cmd_ff == rppc_pkg::CMD_WRITE) && (idx_wide < MAX5);
   assign ram_rd_en = (fe_state_ff == FE_READ);

   rppc_ram #(
      .WIDTH(CUR_W),
      .DEPTH(MAX_STEPS)
   ) u_ram_cur (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(idx_wide[AW-1:0]),
      .wr_data({end_ff, rate_ff, ceil_ff}),
      .rd_en  (ram_rd_en),
      .rd_addr(clip_addr(step_cur5)),
      .rd_data(cur_rd)
   );

   rppc_ram #(
      .WIDTH(NXT_W),
      .DEPTH(MAX_STEPS)
   ) u_ram_nxt (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(idx_wide[AW-1:0]),
      .wr_data({rate_ff, ceil_ff}),
      .rd_en  (ram_rd_en),
      .rd_addr(clip_addr(step_plus)),
      .rd_data(nxt_rd)
   );

   // ------------------------------------------------------------------
   // Update cycle: time, profile step, target ramp and PID error terms
   // ------------------------------------------------------------------
   logic [4:0]              steps5;
   logic [TDW-1:0]          div_inc;
   logic                    sec_wrap;
   logic [TDW-1:0]          tick_div_tick;
   logic [15:0]             seconds_tick;
   logic                    leave_step;
   logic                    enter_cool;
   logic signed [15:0]      use_rate;
   logic [7:0]              use_ceil;
   logic signed [19:0]      ramp_sum;
   logic [17:0]             ramp_sat;
   logic                    ramp_on;
   logic [1:0]              phase_tick;
   logic [3:0]              step_tick;
   logic [17:0]             target_tick;
   logic signed [ERR_W-1:0] err;
   logic signed [ERR_W-1:0] sum_raw;
   logic signed [ERR_W-1:0] lim;
   logic signed [ERR_W-1:0] sum_cl;
   logic signed [ERR_W-1:0] err_diff;
   logic signed [12:0]      temp13;
   logic signed [12:0]      done13;
   logic                    run_tick;
   rppc_pkg::pid_job_type   job;

   assign steps5   = ({1'b0, num_steps_ff} > MAX5) ? MAX5 : {1'b0, num_steps_ff};
   assign run_tick = (cmd_ff == rppc_pkg::CMD_TICK) && (phase_ff != rppc_pkg::PH_IDLE);

   always_comb begin
      // advance the tick divider and the saturating seconds count
      div_inc       = tick_div_ff + TDW'(1);
      sec_wrap      = (div_inc >= TPS_C);
      tick_div_tick = sec_wrap ? '0 : div_inc;
      seconds_tick  = (sec_wrap && (seconds_ff != rppc_pkg::SECONDS_MAX)) ?
                      seconds_ff + 16'd1 : seconds_ff;

      // leave the step once its end time has passed
      leave_step = (seconds_tick > cur_rd[39:24]);
      enter_cool = leave_step && (step_plus >= steps5);
      use_rate   = leave_step ? $signed(nxt_rd[23:8]) : $signed(cur_rd[23:8]);
      use_ceil   = leave_step ? nxt_rd[7:0] : cur_rd[7:0];

      // ramp while below the ceiling, clamped to the target range
      ramp_on  = (target_ff[17:9] < {1'b0, use_ceil});
      ramp_sum = $signed({2'b00, target_ff}) + 20'(use_rate);
      if (ramp_sum < 0) begin
         ramp_sat = '0;
      end else if (ramp_sum > $signed({2'b00, rppc_pkg::TARGET_MAX})) begin
         ramp_sat = rppc_pkg::TARGET_MAX;
      end else begin
         ramp_sat = ramp_sum[17:0];
      end

      phase_tick  = phase_ff;
      step_tick   = step_now_ff;
      target_tick = target_ff;
      if (phase_ff == rppc_pkg::PH_REFLOW) begin
         if (enter_cool) begin
            phase_tick  = rppc_pkg::PH_COOL;
            step_tick   = step_plus[3:0];
            target_tick = rppc_pkg::TARGET_COOL;
         end else begin
            step_tick   = leave_step ? step_plus[3:0] : step_now_ff;
            target_tick = ramp_on ? ramp_sat : target_ff;
         end
      end

      // PID error, clamped integral and derivative term
      err      = $signed({5'b00000, target_tick[17:9]}) - ERR_W'(temp_ff);
      sum_raw  = ERR_W'(error_sum_ff) + err;
      lim      = $signed({6'b000000, int_limit_ff});
      if (sum_raw > lim) begin
         sum_cl = lim;
      end else if (sum_raw < -lim) begin
         sum_cl = -lim;
      end else begin
         sum_cl = sum_raw;
      end
      err_diff = err - prev_err_ff;

      // end cooling once the oven is cool enough
      temp13 = 13'(temp_ff);
      done13 = $signed({5'b00000, done_temp_ff});
      if ((phase_tick == rppc_pkg::PH_COOL) && (temp13 <= done13)) begin
         phase_tick = rppc_pkg::PH_IDLE;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      step_now_in  = step_now_ff;
      tick_div_in  = tick_div_ff;
      seconds_in   = seconds_ff;
      target_in    = target_ff;
      error_sum_in = error_sum_ff;
      prev_err_in  = prev_err_ff;
      if (fe_done) begin
         unique case (cmd_ff)
            rppc_pkg::CMD_START: begin
               phase_in     = rppc_pkg::PH_REFLOW;
               step_now_in  = '0;
               tick_div_in  = '0;
               seconds_in   = '0;
               target_in    = rppc_pkg::TARGET_START;
               error_sum_in = '0;
               prev_err_in  = '0;
            end
            rppc_pkg::CMD_TICK: begin
               if (run_tick) begin
                  phase_in     = phase_tick;
                  step_now_in  = step_tick;
                  tick_div_in  = tick_div_tick;
                  seconds_in   = seconds_tick;
                  target_in    = target_tick;
                  error_sum_in = sum_cl[8:0];
                  prev_err_in  = err;
               end
            end
            default: ;  // profile writes go to the RAMs; unknown codes hold
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= rppc_pkg::PH_IDLE;
         step_now_ff  <= '0;
         tick_div_ff  <= '0;
         seconds_ff   <= '0;
         target_ff    <= rppc_pkg::TARGET_START;
         error_sum_ff <= '0;
         prev_err_ff  <= '0;
      end else begin
         phase_ff     <= phase_in;
         step_now_ff  <= step_now_in;
         tick_div_ff  <= tick_div_in;
         seconds_ff   <= seconds_in;
         target_ff    <= target_in;
         error_sum_ff <= error_sum_in;
         prev_err_ff  <= prev_err_in;
      end
   end

   // hand the error terms and the post-update status to the PID sum unit
   always_comb begin
      job.run_pid                = run_tick;
      job.err                    = err;
      job.err_sum                = sum_cl;
      job.err_diff               = err_diff;
      job.status.target_temp     = target_in[17:9];
      job.status.phase           = phase_in;
      job.status.elapsed_seconds = seconds_in;
      job.status.current_step    = step_now_in;
   end

   // ------------------------------------------------------------------
   // PID sum unit and response register
   // ------------------------------------------------------------------
   logic                 mac_res_valid;
   rppc_pkg::result_type mac_res;
   logic                 out_free;
   logic                 rsp_valid_ff, rsp_valid_in;
   rppc_pkg::result_type rsp_data_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   rppc_pid_mac u_pid_mac (
      .clock    (clock),
      .reset    (reset),
      .gains    (gains_ff),
      .job_valid(fe_state_ff == FE_UPDATE),
      .job      (job),
      .job_ready(mac_job_ready),
      .res_valid(mac_res_valid),
      .res      (mac_res),
      .res_take (out_free)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (mac_res_valid && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // load a finished result; hold it while the receiver stalls
   always_ff @(posedge clock) begin
      if (mac_res_valid && out_free) begin
         rsp_data_ff <= mac_res;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_drive           = rsp_data_ff.drive;
   assign rsp_target_temp     = rsp_data_ff.status.target_temp;
   assign rsp_phase           = rsp_data_ff.status.phase;
   assign rsp_elapsed_seconds = rsp_data_ff.status.elapsed_seconds;
   assign rsp_current_step    = rsp_data_ff.status.current_step;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // the clamped error sum never reaches the one value outside +/-255
   a_err_sum_range: assert property (@(posedge clock) disable iff (reset)
      error_sum_ff != 9'b1_0000_0000)
      else $error("error sum left its clamp range");

   // target and step move only when an update cycle retires
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !fe_done |=> ($stable(target_ff) && $stable(step_now_ff)))
      else $error("controller state changed outside an update");

   // the profile step only advances by one or restarts at zero
   a_step_move: assert property (@(posedge clock) disable iff (reset)
      !$stable(step_now_ff) |->
         ((step_now_ff == $past(step_now_ff) + 4'd1) || (step_now_ff == 4'd0)))
      else $error("profile step jumped");

   // an update cycle always follows the RAM read cycle
   a_read_first: assert property (@(posedge clock) disable iff (reset)
      (fe_state_ff == FE_UPDATE) |->
         (($past(fe_state_ff) == FE_READ) || ($past(fe_state_ff) == FE_UPDATE)))
      else $error("update without a profile read");

   // a response only appears when the PID unit finishes
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(mac_res_valid))
      else $error("response raised without a finished result");

endmodule
